@@ rtl/cral_pkg.sv @@
package cral_pkg;

	// sample magnitude and multiplier operand width
	localparam int MAG_W = 16;
	// radicand width for the root, two bits consumed per step
	localparam int RAD_W = 32;
	localparam int ROOT_STEPS = RAD_W / 2;
	// width that holds any window length or blend weight
	localparam int WIN_W = 17;

	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_BITS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b1;

	localparam logic [5:0] SAMPLE_BITS_RESET = 6'd16;
	localparam logic [3:0] CHANNEL_COUNT_RESET = 4'd1;
	localparam logic [5:0] SAMPLE_BITS_REQ = 6'd16;
	localparam logic [3:0] CHANNEL_COUNT_REQ = 4'd1;

	// 1.0 in sample units
	localparam logic [MAG_W-1:0] FULL_SCALE = 16'd32768;

	typedef struct packed {
		logic signed [MAG_W-1:0] sample;
		logic last;
	} smp_t;

	typedef struct packed {
		logic [MAG_W-1:0] level;
		logic [MAG_W-1:0] chunk_rms;
		logic overflow;
	} lvl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_ACC,
		ST_DLOAD,
		ST_DIV,
		ST_SQRT,
		ST_RMS,
		ST_MUL1,
		ST_MUL2,
		ST_MADD,
		ST_BDONE,
		ST_OUT
	} state_t;

endpackage

@@ rtl/chunk_rms_audio_level.sv @@
// chunk rms audio level meter
//
// smp channel (valid/stall): one signed 16-bit mono sample per word, last marks
// the final sample of a chunk. lvl channel (valid/stall): one word per chunk
// end with the smoothed level, the chunk's own rms and an overflow flag.
// cfg channel (valid/ready, always ready): index 0 sample_bits, 1 channel_count.
// with a format other than 16-bit mono, samples are taken and dropped.
//
// sequence: a sample passes accept, square in the shared multiplier and
// accumulate. a last sample adds the chunk-end sequence on the shared
// subtract unit: a restoring divide of SUM_W quotient bits for the mean, 16
// root steps, and for chunks shorter than LEVEL_WINDOW two multiplies, an add
// and a second divide (SUM_W = 47 with defaults).
// smp_stall is high for the whole time a sample is in work.
//
// the result sits in an output register; new samples are accepted while it
// waits, and a later chunk end holds in its last state until lvl is taken.
// reset (arst_n low) clears the accumulators, history and output valid and
// restores 16-bit mono format; nothing needs a clearing pass.
module chunk_rms_audio_level #(
	parameter int MAX_CHUNK_SAMPLES = 65536,
	parameter int LEVEL_WINDOW = 256
) (
	input  logic clk,
	input  logic arst_n,
	input  logic smp_valid,
	output logic smp_stall,
	input  cral_pkg::smp_t smp,
	output logic lvl_valid,
	input  logic lvl_stall,
	output cral_pkg::lvl_t lvl,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [cral_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cral_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_CHUNK_SAMPLES + 1);
	// max sum is MAX_CHUNK_SAMPLES * 2^30
	localparam int SUM_W = CNT_W + 2 * cral_pkg::MAG_W - 2;
	// trial subtract width: divide remainder or root remainder
	localparam int SU_W = (CNT_W + 1 > 20) ? CNT_W + 1 : 20;
	localparam int ITR_W = $clog2(SUM_W);
	localparam int WIDE_W = CNT_W + cral_pkg::WIN_W;
	localparam int PROD_W = 2 * cral_pkg::MAG_W;

	cral_pkg::state_t state_q, state_d;

	logic [5:0] sample_bits_q;
	logic [3:0] channel_count_q;

	logic [cral_pkg::MAG_W-1:0] mag_q;
	logic last_q;
	logic [PROD_W-1:0] prod_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] count_q;
	logic saturated_q;
	logic [cral_pkg::MAG_W-1:0] prev_rms_q;
	logic [CNT_W-1:0] prev_count_q;

	// shared divide / root datapath
	logic [SUM_W-1:0] dq_q;
	logic [SU_W-1:0] rem_q;
	logic [SU_W-1:0] div_q;
	logic [cral_pkg::MAG_W-1:0] root_q;
	logic [ITR_W-1:0] itr_q;
	logic blend_q;

	logic [cral_pkg::MAG_W-1:0] rms_q;
	logic [cral_pkg::MAG_W-1:0] level_q;

	logic out_valid_q;
	cral_pkg::lvl_t out_q;

	// control
	logic smp_take;
	logic fmt_ok;
	logic out_load;
	logic step_last;

	// combinational datapath
	logic [cral_pkg::MAG_W-1:0] mag_d;
	logic [cral_pkg::MAG_W-1:0] mul_a, mul_b;
	logic [SU_W-1:0] su_a, su_b;
	logic [SU_W:0] su_diff;
	logic su_ge;
	logic [WIDE_W-1:0] count_wide, prev_wide, gap_wide, wt_wide;
	logic do_blend;
	logic [cral_pkg::MAG_W-1:0] rms_clamp;
	logic [cral_pkg::MAG_W-1:0] blend_clamp;

	assign fmt_ok = (sample_bits_q == cral_pkg::SAMPLE_BITS_REQ)
		&& (channel_count_q == cral_pkg::CHANNEL_COUNT_REQ);
	assign smp_take = smp_valid && !smp_stall;
	assign step_last = (itr_q == '0);

	// magnitude, -32768 maps to 32768
	assign mag_d = smp.sample[cral_pkg::MAG_W-1] ? (~smp.sample + 16'd1) : smp.sample;

	// blend weight: min(window - n, previous count)
	assign count_wide = {{cral_pkg::WIN_W{1'b0}}, count_q};
	assign prev_wide = {{cral_pkg::WIN_W{1'b0}}, prev_count_q};
	assign do_blend = count_wide < WIDE_W'(LEVEL_WINDOW);
	assign gap_wide = WIDE_W'(LEVEL_WINDOW) - count_wide;
	assign wt_wide = (gap_wide > prev_wide) ? prev_wide : gap_wide;

	assign rms_clamp = (root_q > cral_pkg::FULL_SCALE) ? cral_pkg::FULL_SCALE : root_q;
	assign blend_clamp = (dq_q > SUM_W'(cral_pkg::FULL_SCALE))
		? cral_pkg::FULL_SCALE : dq_q[cral_pkg::MAG_W-1:0];

	// shared multiplier operand select
	always_comb begin
		unique case (state_q)
			cral_pkg::ST_MUL1: begin
				mul_a = wt_wide[cral_pkg::MAG_W-1:0];
				mul_b = prev_rms_q;
			end
			cral_pkg::ST_MUL2: begin
				mul_a = rms_q;
				mul_b = count_wide[cral_pkg::MAG_W-1:0];
			end
			default: begin
				mul_a = mag_q;
				mul_b = mag_q;
			end
		endcase
	end

	// shared trial subtract: divide step or root step
	always_comb begin
		if (state_q == cral_pkg::ST_SQRT) begin
			su_a = {rem_q[SU_W-3:0], dq_q[cral_pkg::RAD_W-1 -: 2]};
			su_b = {{(SU_W - cral_pkg::MAG_W - 2){1'b0}}, root_q, 2'b01};
		end else begin
			su_a = {rem_q[SU_W-2:0], dq_q[SUM_W-1]};
			su_b = div_q;
		end
	end
	assign su_diff = {1'b0, su_a} - {1'b0, su_b};
	assign su_ge = !su_diff[SU_W];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cral_pkg::ST_IDLE: begin
				if (smp_take && fmt_ok) state_d = cral_pkg::ST_SQUARE;
			end
			cral_pkg::ST_SQUARE: state_d = cral_pkg::ST_ACC;
			cral_pkg::ST_ACC: state_d = last_q ? cral_pkg::ST_DLOAD : cral_pkg::ST_IDLE;
			cral_pkg::ST_DLOAD: state_d = cral_pkg::ST_DIV;
			cral_pkg::ST_DIV: begin
				if (step_last) state_d = blend_q ? cral_pkg::ST_BDONE : cral_pkg::ST_SQRT;
			end
			cral_pkg::ST_SQRT: begin
				if (step_last) state_d = cral_pkg::ST_RMS;
			end
			cral_pkg::ST_RMS: state_d = do_blend ? cral_pkg::ST_MUL1 : cral_pkg::ST_OUT;
			cral_pkg::ST_MUL1: state_d = cral_pkg::ST_MUL2;
			cral_pkg::ST_MUL2: state_d = cral_pkg::ST_MADD;
			cral_pkg::ST_MADD: state_d = cral_pkg::ST_DIV;
			cral_pkg::ST_BDONE: state_d = cral_pkg::ST_OUT;
			cral_pkg::ST_OUT: begin
				if (!out_valid_q || !lvl_stall) state_d = cral_pkg::ST_IDLE;
			end
			default: state_d = cral_pkg::ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		smp_stall = (state_q != cral_pkg::ST_IDLE);
		out_load = (state_q == cral_pkg::ST_OUT) && (!out_valid_q || !lvl_stall);
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cral_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_bits_q <= cral_pkg::SAMPLE_BITS_RESET;
			channel_count_q <= cral_pkg::CHANNEL_COUNT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cral_pkg::REG_SAMPLE_BITS: sample_bits_q <= cfg_data;
				cral_pkg::REG_CHANNEL_COUNT: channel_count_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// chunk accumulators and history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			count_q <= '0;
			saturated_q <= 1'b0;
			prev_rms_q <= '0;
			prev_count_q <= '0;
		end else if (state_q == cral_pkg::ST_ACC) begin
			// count full: sum and count hold, chunk reports overflow
			if (count_q < CNT_W'(MAX_CHUNK_SAMPLES)) begin
				sum_q <= sum_q + SUM_W'(prod_q);
				count_q <= count_q + CNT_W'(1);
			end else begin
				saturated_q <= 1'b1;
			end
		end else if (out_load) begin
			prev_rms_q <= rms_q;
			prev_count_q <= count_q;
			sum_q <= '0;
			count_q <= '0;
			saturated_q <= 1'b0;
		end
	end

	// payload datapath, no reset needed
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(mul_a) * PROD_W'(mul_b);
		if (smp_take) begin
			mag_q <= mag_d;
			last_q <= smp.last;
		end
		unique case (state_q)
			cral_pkg::ST_DLOAD: begin
				// mean = sum / n, n is never zero here
				dq_q <= sum_q;
				rem_q <= '0;
				div_q <= SU_W'(count_q);
				itr_q <= ITR_W'(SUM_W - 1);
				blend_q <= 1'b0;
			end
			cral_pkg::ST_DIV: begin
				dq_q <= {dq_q[SUM_W-2:0], su_ge};
				if (step_last) begin
					// set up the root over the mean
					rem_q <= '0;
					root_q <= '0;
					itr_q <= ITR_W'(cral_pkg::ROOT_STEPS - 1);
				end else begin
					rem_q <= su_ge ? su_diff[SU_W-1:0] : su_a;
					itr_q <= itr_q - ITR_W'(1);
				end
			end
			cral_pkg::ST_SQRT: begin
				dq_q <= {dq_q[SUM_W-3:0], 2'b00};
				rem_q <= su_ge ? su_diff[SU_W-1:0] : su_a;
				root_q <= {root_q[cral_pkg::MAG_W-2:0], su_ge};
				itr_q <= itr_q - ITR_W'(1);
			end
			cral_pkg::ST_RMS: begin
				rms_q <= rms_clamp;
				level_q <= rms_clamp;
			end
			cral_pkg::ST_MUL1: begin
				div_q <= SU_W'(wt_wide[cral_pkg::WIN_W-1:0])
					+ SU_W'(count_wide[cral_pkg::WIN_W-1:0]);
			end
			cral_pkg::ST_MUL2: begin
				dq_q <= SUM_W'(prod_q);
			end
			cral_pkg::ST_MADD: begin
				// numerator w * prev_rms + n * rms over w + n
				dq_q <= dq_q + SUM_W'(prod_q);
				rem_q <= '0;
				itr_q <= ITR_W'(SUM_W - 1);
				blend_q <= 1'b1;
			end
			cral_pkg::ST_BDONE: begin
				level_q <= blend_clamp;
			end
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && lvl_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_q.level <= level_q;
			out_q.chunk_rms <= rms_q;
			out_q.overflow <= saturated_q;
		end
	end

	assign lvl_valid = out_valid_q;
	assign lvl = out_q;

	// overflow only ever set with the count pinned at its bound
	a_sat_full: assert property (@(posedge clk) disable iff (!arst_n)
		saturated_q |-> (count_q == CNT_W'(MAX_CHUNK_SAMPLES)))
		else $error("overflow set below the chunk bound");

	// mean divide never starts on an empty chunk
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cral_pkg::ST_DLOAD) |-> (count_q != '0))
		else $error("chunk end with zero count");

	// root of a mean of squares stays within full scale
	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cral_pkg::ST_RMS) |-> (root_q <= cral_pkg::FULL_SCALE))
		else $error("root above full scale");

	// weighted mean of two in-range values stays in range
	a_blend_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cral_pkg::ST_BDONE) |-> (dq_q <= SUM_W'(cral_pkg::FULL_SCALE)))
		else $error("blended level above full scale");

	// a finished word is never overwritten while the receiver stalls
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && lvl_stall) |-> !out_load)
		else $error("output word overwritten under stall");

endmodule
